// ===== src/psi_pkg.sv =====
`timescale 1ns / 1ps

package psi_pkg;

    // Default geometry of the scanner and the sinogram.
    localparam int TX_BLOCKS_DEF     = 78;
    localparam int AX_BLOCKS_DEF     = 25;
    localparam int TOF_BINS_DEF      = 20;
    localparam int PLANE_SIZE_DEF    = 1989;
    localparam int RING_CRYSTALS_DEF = 312;
    localparam int TOF_BIN_PS_DEF    = 300;

    // Crystals per transaxial block and rings per axial block.
    localparam int TX_PER_BLOCK = 4;
    localparam int AX_PER_BLOCK = 8;

    // Fixed field widths of the request and result items.
    localparam int CRYSTAL_W    = 16;
    localparam int TOF_W        = 16;
    localparam int LOAD_PLANE_W = 11;
    localparam int LOAD_BLOCK_W = 7;
    localparam int ADDR_W       = 25;
    localparam int STATUS_W     = 2;
    localparam int ENTRY_W      = LOAD_PLANE_W + 1;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    localparam longint CRYSTAL_MAX   = 65535;
    localparam longint TOF_NEG_LIMIT = 32768;
    localparam longint TOF_POS_LIMIT = 32767;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_TOF  = 2'd1,
        STATUS_MISS = 2'd2
    } status_t;

    typedef enum logic {
        FUNC_EVENT = 1'b0,
        FUNC_LOAD  = 1'b1
    } func_t;

    // Number of bits needed to hold values from zero up to the argument.
    function automatic int bits_for(longint value);
        int n;
        n = 1;
        while (n < 62 && (longint'(1) << n) <= value) begin
            n = n + 1;
        end
        return n;
    endfunction

    function automatic longint max_of(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== src/pet_event_sinogram_indexer.sv =====
`timescale 1ns / 1ps
// A result is offered once its event request has passed stages 0 to 6 and the output register.
// Throughput: one request per cycle while the skid register is empty; load requests give no result.
// The block-pair table sits in a dual-read memory read in pipeline stage 3.
// Reset (aresetn low, synchronous) empties the pipeline and then sweeps all TX_BLOCKS*TX_BLOCKS
// table entries (6084 by default) to invalid, one entry a cycle, with s_tready low.
module pet_event_sinogram_indexer #(
    parameter int TX_BLOCKS     = psi_pkg::TX_BLOCKS_DEF,
    parameter int AX_BLOCKS     = psi_pkg::AX_BLOCKS_DEF,
    parameter int TOF_BINS      = psi_pkg::TOF_BINS_DEF,
    parameter int PLANE_SIZE    = psi_pkg::PLANE_SIZE_DEF,
    parameter int RING_CRYSTALS = psi_pkg::RING_CRYSTALS_DEF,
    parameter int TOF_BIN_PS    = psi_pkg::TOF_BIN_PS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // crystal_a, crystal_b, tof_ps, load_plane_index, load_block_row, load_block_col
    input  logic [psi_pkg::S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // sino_address
    output logic [psi_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [psi_pkg::STATUS_W-1:0]   m_tuser
);
    import psi_pkg::*;

    // Table geometry.
    localparam int DEPTH = TX_BLOCKS * TX_BLOCKS;
    localparam int MA_W  = bits_for(DEPTH - 1);

    // Crystal id split.
    localparam longint RING_MAX = CRYSTAL_MAX / RING_CRYSTALS;
    localparam int     RING_W   = bits_for(RING_MAX);
    localparam int     POS_W    = bits_for(RING_CRYSTALS - 1);
    localparam int     TXB_W    = bits_for((RING_CRYSTALS - 1) / TX_PER_BLOCK);
    localparam longint AXB_MAX  = RING_MAX / AX_PER_BLOCK;
    localparam int     AXB_W    = bits_for(AXB_MAX);

    // TOF binning: the offset makes the dividend positive so the floor is exact.
    localparam longint TOF_OFS_N  = (TOF_NEG_LIMIT + TOF_BIN_PS - 1) / TOF_BIN_PS;
    localparam longint TOF_OFS_PS = TOF_OFS_N * TOF_BIN_PS;
    localparam longint U_MAX      = TOF_POS_LIMIT + TOF_OFS_PS;
    localparam int     U_W        = int'(max_of(17, bits_for(U_MAX)));
    localparam int     QT_W       = bits_for(U_MAX / TOF_BIN_PS);
    localparam int     TR_W       = bits_for(TOF_BIN_PS - 1);
    localparam int     TI_W       = bits_for(TOF_BINS);
    localparam int     BIN_W      = int'(max_of(QT_W, TI_W)) + 2;
    localparam int     HALF       = TOF_BINS / 2;

    localparam logic signed [BIN_W-1:0] OFS_S   = BIN_W'(TOF_OFS_N);
    localparam logic signed [BIN_W-1:0] ONE_S   = BIN_W'(1);
    localparam logic signed [BIN_W-1:0] HALF_S  = BIN_W'(HALF);
    localparam logic signed [BIN_W-1:0] HALF2_S = BIN_W'(2 * HALF);
    localparam logic signed [BIN_W-1:0] TBM1_S  = BIN_W'(TOF_BINS - 1);

    // Flat address terms.
    localparam longint AXL_MAX  = AXB_MAX + longint'(AX_BLOCKS) * AXB_MAX;
    localparam int     AXL_W    = bits_for(AXL_MAX);
    localparam longint AXT_MAX  = longint'(PLANE_SIZE) * AXL_MAX;
    localparam int     AXT_W    = bits_for(AXT_MAX);
    localparam longint TOF_STEP = longint'(PLANE_SIZE) * AX_BLOCKS * AX_BLOCKS;
    localparam longint TOTAL    = TOF_STEP * TOF_BINS;
    localparam longint SUM_MAX  = (longint'(1) << LOAD_PLANE_W) + AXT_MAX + TOTAL;
    localparam int     SUM_W    = bits_for(max_of(SUM_MAX, TOTAL));

    localparam logic [SUM_W-1:0] TOTAL_V = SUM_W'(TOTAL);

    // Pipeline control.
    logic adv;
    logic clr_active_reg;
    logic [MA_W-1:0] clr_addr_reg;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic out_valid_reg, skid_valid_reg;

    // Stage 0: accepted request.
    logic                    load0_reg;
    logic [CRYSTAL_W-1:0]    ca0_reg, cb0_reg;
    logic [TOF_W-1:0]        tof0_reg;
    logic [LOAD_PLANE_W-1:0] lpl0_reg;
    logic [LOAD_BLOCK_W-1:0] lrow0_reg, lcol0_reg;

    // Stages 1 and 2: division in flight, load fields carried along.
    logic [U_W-1:0]          tof_u;
    logic                    ld_ok;
    logic [MA_W-1:0]         wr_addr_next;
    logic                    load1_reg, load2_reg, load3_reg;
    logic                    wr_en1_reg, wr_en2_reg, wr_en3_reg;
    logic [MA_W-1:0]         wr_addr1_reg, wr_addr2_reg, wr_addr3_reg;
    logic [LOAD_PLANE_W-1:0] pl1_reg, pl2_reg, pl3_reg;

    logic [RING_W-1:0] ring_a, ring_b;
    logic [POS_W-1:0]  pos_a, pos_b;
    logic [QT_W-1:0]   tof_q;
    logic [TR_W-1:0]   tof_r;

    // Stage 3: block numbers, TOF window, table addresses.
    logic [TXB_W-1:0]        txa, txb;
    logic [AXB_W-1:0]        axa, axb;
    logic signed [BIN_W-1:0] bin_raw, bin_adj, fwd_s, rev_s;
    logic                    win_ok, tx_ok;
    logic [MA_W-1:0]         rd_f_next, rd_r_next;
    logic [AXL_W-1:0]        ax_lin_next;

    logic              win3_reg, tx_ok3_reg;
    logic [TI_W-1:0]   fwd3_reg, rev3_reg;
    logic [MA_W-1:0]   rd_f3_reg, rd_r3_reg;
    logic [AXL_W-1:0]  ax_lin3_reg;

    // Table memory and its registered read data (stage 4).
    logic [ENTRY_W-1:0] pair_mem [DEPTH];
    logic [ENTRY_W-1:0] rd_f4_reg, rd_r4_reg;
    logic               win4_reg, tx_ok4_reg;
    logic [TI_W-1:0]    fwd4_reg, rev4_reg;
    logic [AXL_W-1:0]   ax_lin4_reg;

    // Stage 5: pair selection.
    logic                    fwd_hit, rev_hit;
    status_t                 stat_next;
    status_t                 stat5_reg, stat6_reg;
    logic [LOAD_PLANE_W-1:0] plane5_reg;
    logic [TI_W-1:0]         tidx5_reg;
    logic [AXT_W-1:0]        ax_term5_reg;

    // Stage 6: partial sums.
    logic [SUM_W-1:0] tof_term6_reg, part6_reg;

    // Result and output registers.
    logic [SUM_W-1:0]  res_sum;
    status_t           res_status;
    logic [ADDR_W-1:0] res_addr;
    status_t           out_status_reg, skid_status_reg;
    logic [ADDR_W-1:0] out_addr_reg, skid_addr_reg;
    logic              out_load, skid_load, skid_pop;

    // The pipeline moves as a whole while the skid register is empty.
    assign adv      = !skid_valid_reg;
    assign s_tready = adv && !clr_active_reg;

    // Table clearing sweep after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else if (clr_active_reg) begin
            if (clr_addr_reg == MA_W'(DEPTH - 1)) begin
                clr_active_reg <= 1'b0;
            end else begin
                clr_addr_reg <= clr_addr_reg + MA_W'(1);
            end
        end
    end

    // Valid bits travel with the data; loads leave after stage 3.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid && s_tready;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg && !load3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Stage 0 capture of the request fields.
    always_ff @(posedge aclk) begin
        if (adv) begin
            load0_reg <= (func_t'(s_tuser) == FUNC_LOAD);
            ca0_reg   <= s_tdata[15:0];
            cb0_reg   <= s_tdata[31:16];
            tof0_reg  <= s_tdata[47:32];
            lpl0_reg  <= s_tdata[58:48];
            lrow0_reg <= s_tdata[65:59];
            lcol0_reg <= s_tdata[72:66];
        end
    end

    // Offset TOF so that floor division runs on an unsigned value.
    assign tof_u = {{(U_W - TOF_W){tof0_reg[TOF_W-1]}}, tof0_reg} + U_W'(TOF_OFS_PS);

    // Load entry check and table address; block numbers count from one.
    assign ld_ok = (lrow0_reg != '0) && (int'(lrow0_reg) <= TX_BLOCKS)
                && (lcol0_reg != '0) && (int'(lcol0_reg) <= TX_BLOCKS)
                && (int'(lpl0_reg) < PLANE_SIZE);
    assign wr_addr_next = ld_ok
        ? MA_W'(32'(lrow0_reg - LOAD_BLOCK_W'(1)) * 32'(TX_BLOCKS)
                + 32'(lcol0_reg - LOAD_BLOCK_W'(1)))
        : '0;

    psi_const_div #(
        .IN_W    (CRYSTAL_W),
        .DIVISOR (RING_CRYSTALS),
        .Q_W     (RING_W),
        .R_W     (POS_W)
    ) u_div_a (
        .aclk      (aclk),
        .en        (adv),
        .dividend  (ca0_reg),
        .quotient  (ring_a),
        .remainder (pos_a)
    );

    psi_const_div #(
        .IN_W    (CRYSTAL_W),
        .DIVISOR (RING_CRYSTALS),
        .Q_W     (RING_W),
        .R_W     (POS_W)
    ) u_div_b (
        .aclk      (aclk),
        .en        (adv),
        .dividend  (cb0_reg),
        .quotient  (ring_b),
        .remainder (pos_b)
    );

    psi_const_div #(
        .IN_W    (U_W),
        .DIVISOR (TOF_BIN_PS),
        .Q_W     (QT_W),
        .R_W     (TR_W)
    ) u_div_tof (
        .aclk      (aclk),
        .en        (adv),
        .dividend  (tof_u),
        .quotient  (tof_q),
        .remainder (tof_r)
    );

    // Load fields ride alongside the division stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            load1_reg    <= load0_reg;
            wr_en1_reg   <= load0_reg && ld_ok;
            wr_addr1_reg <= wr_addr_next;
            pl1_reg      <= lpl0_reg;
            load2_reg    <= load1_reg;
            wr_en2_reg   <= wr_en1_reg;
            wr_addr2_reg <= wr_addr1_reg;
            pl2_reg      <= pl1_reg;
        end
    end

    // Block numbers of both crystals.
    assign txa = TXB_W'(pos_a / TX_PER_BLOCK);
    assign txb = TXB_W'(pos_b / TX_PER_BLOCK);
    assign axa = AXB_W'(ring_a / AX_PER_BLOCK);
    assign axb = AXB_W'(ring_b / AX_PER_BLOCK);

    // TOF bin: floor, then negative bins step one further down.
    always_comb begin
        bin_raw = $signed(BIN_W'(tof_q)) - OFS_S;
        if (bin_raw < 0) begin
            bin_adj = bin_raw - ONE_S;
        end else begin
            bin_adj = bin_raw;
        end
        fwd_s  = bin_adj + HALF_S;
        rev_s  = HALF2_S - fwd_s;
        win_ok = !fwd_s[BIN_W-1] && (fwd_s <= TBM1_S);
    end

    // Forward and reversed table addresses; the remainder of the TOF division is a check only.
    assign tx_ok       = (int'(txa) < TX_BLOCKS) && (int'(txb) < TX_BLOCKS)
                      && (int'(tof_r) < TOF_BIN_PS);
    assign rd_f_next   = tx_ok ? MA_W'(32'(txa) * 32'(TX_BLOCKS) + 32'(txb)) : '0;
    assign rd_r_next   = tx_ok ? MA_W'(32'(txb) * 32'(TX_BLOCKS) + 32'(txa)) : '0;
    assign ax_lin_next = AXL_W'(axa) + AXL_W'(axb) * AXL_W'(AX_BLOCKS);

    always_ff @(posedge aclk) begin
        if (adv) begin
            load3_reg    <= load2_reg;
            wr_en3_reg   <= wr_en2_reg;
            wr_addr3_reg <= wr_addr2_reg;
            pl3_reg      <= pl2_reg;
            win3_reg     <= win_ok;
            tx_ok3_reg   <= tx_ok;
            fwd3_reg     <= TI_W'(fwd_s);
            rev3_reg     <= TI_W'(rev_s);
            rd_f3_reg    <= rd_f_next;
            rd_r3_reg    <= rd_r_next;
            ax_lin3_reg  <= ax_lin_next;
        end
    end

    // Table write port: the clearing sweep, otherwise a load leaving stage 3.
    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            pair_mem[clr_addr_reg] <= '0;
        end else if (adv && v3_reg && wr_en3_reg) begin
            pair_mem[wr_addr3_reg] <= {1'b1, pl3_reg};
        end
    end

    // Table read ports for the forward and the reversed pair.
    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_f4_reg <= pair_mem[rd_f3_reg];
            rd_r4_reg <= pair_mem[rd_r3_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            win4_reg    <= win3_reg;
            tx_ok4_reg  <= tx_ok3_reg;
            fwd4_reg    <= fwd3_reg;
            rev4_reg    <= rev3_reg;
            ax_lin4_reg <= ax_lin3_reg;
        end
    end

    // Pick the forward pair if present, else the reversed one with the TOF bin negated.
    assign fwd_hit = tx_ok4_reg && rd_f4_reg[ENTRY_W-1];
    assign rev_hit = tx_ok4_reg && rd_r4_reg[ENTRY_W-1];

    always_comb begin
        priority if (!win4_reg) begin
            stat_next = STATUS_TOF;
        end else if (!fwd_hit && !rev_hit) begin
            stat_next = STATUS_MISS;
        end else begin
            stat_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stat5_reg    <= stat_next;
            plane5_reg   <= fwd_hit ? rd_f4_reg[LOAD_PLANE_W-1:0] : rd_r4_reg[LOAD_PLANE_W-1:0];
            tidx5_reg    <= fwd_hit ? fwd4_reg : rev4_reg;
            ax_term5_reg <= AXT_W'(ax_lin4_reg) * AXT_W'(PLANE_SIZE);
        end
    end

    // TOF term and the sum of plane and axial terms.
    always_ff @(posedge aclk) begin
        if (adv) begin
            stat6_reg     <= stat5_reg;
            tof_term6_reg <= SUM_W'(tidx5_reg) * SUM_W'(TOF_STEP);
            part6_reg     <= SUM_W'(plane5_reg) + SUM_W'(ax_term5_reg);
        end
    end

    // Final address and range check.
    assign res_sum    = part6_reg + tof_term6_reg;
    assign res_status = (stat6_reg == STATUS_OK && res_sum >= TOTAL_V) ? STATUS_MISS
                                                                      : stat6_reg;
    assign res_addr   = (res_status == STATUS_OK) ? ADDR_W'(res_sum) : '0;

    // Output register with a skid register behind it.
    assign out_load  = adv && v6_reg && (!out_valid_reg || m_tready);
    assign skid_load = adv && v6_reg && out_valid_reg && !m_tready;
    assign skid_pop  = skid_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (v6_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= out_valid_reg && !m_tready;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_pop) begin
            out_status_reg <= skid_status_reg;
            out_addr_reg   <= skid_addr_reg;
        end else if (out_load) begin
            out_status_reg <= res_status;
            out_addr_reg   <= res_addr;
        end
        if (skid_load) begin
            skid_status_reg <= res_status;
            skid_addr_reg   <= res_addr;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_addr_reg);
    assign m_tuser  = out_status_reg;

endmodule

// ===== src/psi_const_div.sv =====
`timescale 1ns / 1ps

module psi_const_div #(
    parameter int IN_W    = 16,
    parameter int DIVISOR = 312,
    parameter int Q_W     = 8,
    parameter int R_W     = 9
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [IN_W-1:0] dividend,
    output logic [Q_W-1:0]  quotient,
    output logic [R_W-1:0]  remainder
);
    import psi_pkg::*;

    // The reciprocal is scaled so that the estimate is at most one below the quotient.
    localparam int     SHIFT   = IN_W + bits_for(DIVISOR);
    localparam longint RECIP   = (longint'(1) << SHIFT) / DIVISOR;
    localparam int     RECIP_W = bits_for(RECIP);
    localparam int     PROD_W  = IN_W + RECIP_W;

    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    est_next;
    logic [Q_W-1:0]    est_reg;
    logic [IN_W-1:0]   x_reg;
    logic [IN_W-1:0]   rem_raw;
    logic              rem_over;
    logic [Q_W-1:0]    quot_next;
    logic [R_W-1:0]    rem_next;
    logic [Q_W-1:0]    quot_reg;
    logic [R_W-1:0]    rem_reg;

    // First stage: multiply by the reciprocal.
    assign prod     = PROD_W'(dividend) * PROD_W'(RECIP);
    assign est_next = Q_W'(prod >> SHIFT);

    always_ff @(posedge aclk) begin
        if (en) begin
            est_reg <= est_next;
            x_reg   <= dividend;
        end
    end

    // Second stage: form the remainder and correct the estimate by one step.
    assign rem_raw   = x_reg - IN_W'(IN_W'(est_reg) * IN_W'(DIVISOR));
    assign rem_over  = (rem_raw >= IN_W'(DIVISOR));
    assign quot_next = est_reg + Q_W'(rem_over);
    assign rem_next  = rem_over ? R_W'(rem_raw - IN_W'(DIVISOR)) : R_W'(rem_raw);

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ===== dv/tb_pet_event_sinogram_indexer.sv =====
`timescale 1ns / 1ps

module tb_pet_event_sinogram_indexer;
    import psi_pkg::*;

    localparam int     PAIR_COUNT    = TX_BLOCKS_DEF * TX_BLOCKS_DEF;
    localparam int     TOF_HALF      = TOF_BINS_DEF / 2;
    localparam longint BINS_TOTAL    = longint'(PLANE_SIZE_DEF) * AX_BLOCKS_DEF
                                       * AX_BLOCKS_DEF * TOF_BINS_DEF;
    localparam int     SETTLE_CYCLES = 20;

    typedef struct {
        status_t           status;
        logic [ADDR_W-1:0] address;
    } sino_bin_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // Predictor state: block-pair table entries (valid bit over plane index).
    logic [ENTRY_W-1:0] pair_plane [PAIR_COUNT];
    logic [13:0]        loaded_pairs[$];
    sino_bin_t          expected_bins[$];

    int mismatch_count   = 0;
    int hold_cycles      = 0;
    bit sender_idle_on   = 1'b1;
    bit receiver_idle_on = 1'b1;

    pet_event_sinogram_indexer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(string field, longint got, longint want);
        $display("ERROR at %0t ns: %s is %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    // A load only lands when both block numbers and the plane are in range.
    function automatic void store_pair_plane(logic [10:0] plane, logic [6:0] row,
                                             logic [6:0] col);
        if (row >= 1 && row <= TX_BLOCKS_DEF && col >= 1 && col <= TX_BLOCKS_DEF
                && plane < PLANE_SIZE_DEF) begin
            pair_plane[(row - 1) * TX_BLOCKS_DEF + (col - 1)] = {1'b1, plane};
            loaded_pairs.push_back({row, col});
        end
    endfunction

    // Computes the sinogram bin and status that one event should produce.
    function automatic sino_bin_t predict_sino_bin(logic [15:0] ca, logic [15:0] cb,
                                                   logic signed [15:0] tof);
        sino_bin_t          res;
        int                 tof_val, bin, tof_idx, txa, txb, axa, axb;
        logic [ENTRY_W-1:0] fwd, rev, hit;
        longint             addr;
        res.status  = STATUS_OK;
        res.address = '0;
        tof_val = int'(tof);

        // Floor division, then negative bins move one further out.
        bin = tof_val / TOF_BIN_PS_DEF;
        if (tof_val % TOF_BIN_PS_DEF != 0 && tof_val < 0) bin = bin - 1;
        if (bin < 0) bin = bin - 1;
        if (bin + TOF_HALF > TOF_BINS_DEF - 1 || bin + TOF_HALF < 0) begin
            res.status = STATUS_TOF;
            return res;
        end

        txa = (int'(ca) % RING_CRYSTALS_DEF) / TX_PER_BLOCK;
        txb = (int'(cb) % RING_CRYSTALS_DEF) / TX_PER_BLOCK;
        axa = (int'(ca) / RING_CRYSTALS_DEF) / AX_PER_BLOCK;
        axb = (int'(cb) / RING_CRYSTALS_DEF) / AX_PER_BLOCK;

        // Forward pair first; the reversed pair mirrors the TOF bin.
        fwd = pair_plane[txa * TX_BLOCKS_DEF + txb];
        rev = pair_plane[txb * TX_BLOCKS_DEF + txa];
        if (fwd[ENTRY_W-1]) begin
            hit     = fwd;
            tof_idx = bin + TOF_HALF;
        end else if (rev[ENTRY_W-1]) begin
            hit     = rev;
            tof_idx = TOF_HALF - bin;
        end else begin
            res.status = STATUS_MISS;
            return res;
        end

        addr = longint'(hit[LOAD_PLANE_W-1:0])
             + longint'(PLANE_SIZE_DEF) * axa
             + longint'(PLANE_SIZE_DEF) * AX_BLOCKS_DEF * axb
             + longint'(PLANE_SIZE_DEF) * AX_BLOCKS_DEF * AX_BLOCKS_DEF * tof_idx;
        if (addr < 0 || addr > BINS_TOTAL - 1) begin
            res.status = STATUS_MISS;
            return res;
        end
        res.address = addr[ADDR_W-1:0];
        return res;
    endfunction

    // Offers one request, waits for the handshake, then updates the prediction.
    task automatic send_request(func_t func, logic [15:0] ca, logic [15:0] cb,
                                logic [15:0] tof, logic [10:0] plane,
                                logic [6:0] row, logic [6:0] col);
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        // Seven zero bits pad the 73 field bits up to whole bytes.
        s_tdata  <= {7'd0, col, row, plane, tof, cb, ca};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (func == FUNC_LOAD) begin
            store_pair_plane(plane, row, col);
        end else begin
            expected_bins.push_back(predict_sino_bin(ca, cb, tof));
        end
    endtask

    task automatic send_load(logic [10:0] plane, logic [6:0] row, logic [6:0] col);
        send_request(FUNC_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), plane, row, col);
    endtask

    task automatic send_event(logic [15:0] ca, logic [15:0] cb, logic [15:0] tof);
        send_request(FUNC_EVENT, ca, cb, tof, 11'($urandom), 7'($urandom), 7'($urandom));
    endtask

    // Crystal id in a given transaxial block, usually on a ring of the scanner.
    function automatic logic [15:0] crystal_in_block(int tx);
        int ring;
        ring = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 209) : $urandom_range(0, 199);
        return 16'(ring * RING_CRYSTALS_DEF + tx * TX_PER_BLOCK
                   + int'($urandom_range(0, 3)));
    endfunction

    // Mostly events on loaded pairs with TOF near the window, plus loads and noise.
    task automatic send_random_item();
        int          pick, row, col;
        logic [15:0] ca, cb, tof;
        logic [10:0] plane;
        logic [13:0] pair;
        pick  = int'($urandom_range(0, 99));
        ca    = 16'($urandom);
        cb    = 16'($urandom);
        tof   = 16'($urandom);
        plane = 11'($urandom);
        row   = int'($urandom_range(0, 127));
        col   = int'($urandom_range(0, 127));
        if (pick < 18) begin
            send_load(11'($urandom_range(0, PLANE_SIZE_DEF - 1)),
                      7'($urandom_range(1, TX_BLOCKS_DEF)),
                      7'($urandom_range(1, TX_BLOCKS_DEF)));
        end else if (pick < 22) begin
            send_request(FUNC_LOAD, ca, cb, tof, plane, row[6:0], col[6:0]);
        end else begin
            if (pick < 85 && loaded_pairs.size() > 0) begin
                pair = loaded_pairs[$urandom_range(0, loaded_pairs.size() - 1)];
                row  = int'(pair[13:7]);
                col  = int'(pair[6:0]);
                // Half the events name the pair backwards.
                if ($urandom_range(0, 1) == 1) begin
                    ca = crystal_in_block(col - 1);
                    cb = crystal_in_block(row - 1);
                end else begin
                    ca = crystal_in_block(row - 1);
                    cb = crystal_in_block(col - 1);
                end
            end else if (pick < 92) begin
                ca = crystal_in_block(int'($urandom_range(0, TX_BLOCKS_DEF - 1)));
                cb = crystal_in_block(int'($urandom_range(0, TX_BLOCKS_DEF - 1)));
            end
            if ($urandom_range(0, 9) < 8) tof = 16'(int'($urandom_range(0, 6299)) - 3000);
            send_request(FUNC_EVENT, ca, cb, tof, plane, row[6:0], col[6:0]);
        end
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_bins.size() != 0);
    endtask

    task automatic test_empty_table();
        send_event(16'd0, 16'd0, 16'd0);
        send_event(16'd62399, 16'd62399, 16'h7FFF);
    endtask

    task automatic test_directed_loads();
        send_load(11'd0, 7'd1, 7'd1);
        send_load(11'd1988, 7'd78, 7'd78);
        send_load(11'd1234, 7'd78, 7'd1);
        send_load(11'd7, 7'd4, 7'd4);
        // Block numbers or plane out of range leave the table untouched.
        send_load(11'd3, 7'd0, 7'd5);
        send_load(11'd3, 7'd5, 7'd0);
        send_load(11'd3, 7'd79, 7'd5);
        send_load(11'd3, 7'd127, 7'd127);
        send_load(11'd1989, 7'd2, 7'd2);
        send_load(11'd2047, 7'd2, 7'd2);
        // A second load of the same pair replaces the first.
        send_load(11'd100, 7'd1, 7'd1);
    endtask

    task automatic test_directed_events();
        send_event(16'd0, 16'd0, 16'd0);
        send_event(16'd62399, 16'd62399, 16'd2999);
        send_event(16'd62399, 16'd62399, 16'd3000);
        send_event(16'd0, 16'd0, -16'sd2700);
        send_event(16'd0, 16'd0, -16'sd2701);
        send_event(16'd0, 16'd0, -16'sd1);
        send_event(16'd0, 16'd0, -16'sd300);
        send_event(16'd0, 16'd0, -16'sd301);
        // Only the reversed pair is loaded here.
        send_event(16'd0, 16'd62399, 16'd2999);
        send_event(16'd0, 16'd62399, -16'sd2700);
        // Pairs missing both ways, one of them hit only by rejected loads.
        send_event(16'd8, 16'd4, 16'd0);
        send_event(16'd4, 16'd4, 16'd0);
        // Axial blocks past the scanner alias or overflow the sinogram.
        send_event(16'd65535, 16'd65535, -16'sd2700);
        send_event(16'd65535, 16'd65535, 16'd2999);
    endtask

    task automatic test_back_pressure();
        sender_idle_on = 1'b0;
        hold_cycles    = 150;
        repeat (60) send_random_item();
        sender_idle_on = 1'b1;
        wait_for_drain();
    endtask

    task automatic test_drain_pause();
        repeat (40) send_random_item();
        wait_for_drain();
        repeat (40) send_random_item();
    endtask

    task automatic test_random_traffic();
        repeat (1200) send_random_item();
    endtask

    task automatic test_steady_stream();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        repeat (150) send_random_item();
    endtask

    // Compares one accepted result against the oldest expectation.
    task automatic check_result();
        sino_bin_t want;
        if (expected_bins.size() == 0) begin
            report_mismatch("unexpected result, status", longint'(m_tuser), -1);
            return;
        end
        want = expected_bins.pop_front();
        if (m_tuser !== want.status) begin
            report_mismatch("status", longint'(m_tuser), longint'(want.status));
        end
        if (m_tdata[ADDR_W-1:0] !== want.address) begin
            report_mismatch("sino_address", longint'(m_tdata[ADDR_W-1:0]),
                            longint'(want.address));
        end
    endtask

    // Result side: long hold-offs on request, short random stalls otherwise.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) check_result();
            if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = int'($urandom_range(1, 4)) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_EVENT;
        foreach (pair_plane[i]) pair_plane[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_directed_loads();
        test_directed_events();
        test_back_pressure();
        test_drain_pause();
        test_random_traffic();
        test_steady_stream();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/psi_pkg.sv
src/psi_const_div.sv
src/pet_event_sinogram_indexer.sv
dv/tb_pet_event_sinogram_indexer.sv
